[rtl/core/tlbsa_pkg.sv]
// shared types, constants and search functions for the two-level bitmap slot allocator
package tlbsa_pkg;

   // store geometry
   localparam int NUM_WORDS   = 32;
   localparam int WORD_BITS   = 32;
   localparam int WIDX_W      = $clog2(NUM_WORDS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int TOTAL_SLOTS = NUM_WORDS * WORD_BITS;
   localparam int COUNT_W     = $clog2(TOTAL_SLOTS + 1);

   // field widths of the channels
   localparam int SLOT_W      = 10;
   localparam int CNT_W       = 11;
   localparam int THR_W       = 11;
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(768);

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic              command;
      logic [SLOT_W-1:0] start_slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic              failed;
      logic [CNT_W-1:0]  slots_used;
      logic              past_threshold;
   } rsp_type;

   // lowest set bit of a word
   function automatic logic [BIT_W-1:0] find_bit(input logic [WORD_BITS-1:0] vec);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (vec[i]) idx = BIT_W'(i);
      end
      return idx;
   endfunction

   // lowest set bit of a word-level vector
   function automatic logic [WIDX_W-1:0] find_word(input logic [NUM_WORDS-1:0] vec);
      logic [WIDX_W-1:0] idx;
      idx = '0;
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
         if (vec[i]) idx = WIDX_W'(i);
      end
      return idx;
   endfunction

   // word number plus offset, wrapped around the store
   function automatic logic [WIDX_W-1:0] wrap_add(input logic [WIDX_W-1:0] base,
                                                  input logic [WIDX_W-1:0] offs);
      logic [WIDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= (WIDX_W + 1)'(NUM_WORDS)) sum = sum - (WIDX_W + 1)'(NUM_WORDS);
      return sum[WIDX_W-1:0];
   endfunction

endpackage

[rtl/core/two_level_bitmap_slot_allocator.sv]
// two-level bitmap slot allocator: word store, full-word summary and search sequencer
//
//   channel  dir  handshake          carries
//   req      in   req_valid/stall    req_type: command, start_slot
//   rsp      out  rsp_valid/stall    rsp_type: slot_index, failed, slots_used, past_threshold
//   csr      in   csr_valid/ready    retire threshold, 11 bits
//
// clear: result registered in the cycle after the transfer.
// allocate: the result is registered from state LOOK0 when the start word holds a free slot at or
// above the start bit, and also when the search falls back to the start word's low bits or fails;
// from state LOOK1, after a registered read of the next non-full word, when the search moves there.
// one item in flight: req_stall stays high until the result has been transferred.
// reset empties the store through per-word valid bits and sets the threshold to 768.
module two_level_bitmap_slot_allocator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tlbsa_pkg::req_type        req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tlbsa_pkg::rsp_type        rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [tlbsa_pkg::THR_W-1:0] csr_data
);
   import tlbsa_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOOK0 = 2'd1;
   localparam logic [1:0] S_LOOK1 = 2'd2;

   // word store and its read port
   logic [WORD_BITS-1:0] slot_mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [WIDX_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [WIDX_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // control and status state
   logic [1:0]           state_ff, state_in;
   logic [NUM_WORDS-1:0] word_vld_ff, word_vld_in;
   logic [NUM_WORDS-1:0] full_ff, full_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [WIDX_W-1:0]    cur_w_ff, cur_w_in;
   logic [BIT_W-1:0]     b0_ff, b0_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // search datapath
   logic                 accept;
   logic [WIDX_W-1:0]    req_w0;
   logic [BIT_W-1:0]     req_b0;
   logic [WORD_BITS-1:0] word;
   logic [WORD_BITS-1:0] hi_mask;
   logic [WORD_BITS-1:0] free_hi;
   logic [WORD_BITS-1:0] free_lo;
   logic [WORD_BITS-1:0] find_vec;
   logic [BIT_W-1:0]     find_idx;
   logic [NUM_WORDS-1:0] nonfull_rot;
   logic                 nonfull_any;
   logic [WIDX_W-1:0]    next_w;
   logic [WORD_BITS-1:0] taken_word;
   logic                 take;
   logic                 fail;
   logic [COUNT_W-1:0]   count_take;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // start position split into word and bit
   assign req_w0 = WIDX_W'((int'(req_data.start_slot) / WORD_BITS) % NUM_WORDS);
   assign req_b0 = BIT_W'(int'(req_data.start_slot) % WORD_BITS);

   // word read back, unwritten words read as free
   assign word = rd_vld_ff ? rd_data_ff : '0;

   // eligible bits at and above the start bit
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         hi_mask[i] = (BIT_W'(i) >= b0_ff);
      end
   end

   assign free_hi = ~word & hi_mask;
   assign free_lo = ~word & ~hi_mask;

   // summary search: next non-full word after the start word, in circular order
   always_comb begin
      nonfull_rot[0] = 1'b0;
      for (int k = 1; k < NUM_WORDS; k++) begin
         nonfull_rot[k] = !full_ff[wrap_add(cur_w_ff, WIDX_W'(k))];
      end
   end

   assign nonfull_any = |nonfull_rot;
   assign next_w      = wrap_add(cur_w_ff, find_word(nonfull_rot));

   // shared find-first-free unit
   always_comb begin
      if (state_ff == S_LOOK1) begin
         find_vec = ~word;
      end else if (free_hi != '0) begin
         find_vec = free_hi;
      end else begin
         find_vec = free_lo;
      end
   end

   assign find_idx   = find_bit(find_vec);
   assign taken_word = word | (WORD_BITS'(1) << find_idx);
   assign count_take = count_ff + COUNT_W'(1);

   // take or fail decision per search step
   always_comb begin
      take = 1'b0;
      fail = 1'b0;
      case (state_ff)
         S_LOOK0: begin
            if (free_hi != '0) begin
               take = 1'b1;
            end else if (nonfull_any) begin
               take = 1'b0;
            end else if (free_lo != '0) begin
               take = 1'b1;
            end else begin
               fail = 1'b1;
            end
         end
         S_LOOK1: begin
            take = 1'b1;
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   assign rd_addr = (state_ff == S_IDLE) ? req_w0 : next_w;
   assign wr_en   = take;
   assign wr_addr = cur_w_ff;
   assign wr_data = taken_word;

   // sequencer and state updates
   always_comb begin
      state_in     = state_ff;
      word_vld_in  = word_vld_ff;
      full_in      = full_ff;
      count_in     = count_ff;
      thr_in       = thr_ff;
      cur_w_in     = cur_w_ff;
      b0_in        = b0_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) thr_in = csr_data;

      // result leaves on a transfer
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.command == CMD_CLEAR) begin
                  word_vld_in               = '0;
                  full_in                   = '0;
                  count_in                  = '0;
                  rsp_valid_in              = 1'b1;
                  rsp_in.slot_index         = '0;
                  rsp_in.failed             = 1'b0;
                  rsp_in.slots_used         = '0;
                  rsp_in.past_threshold     = (thr_ff == '0);
               end else begin
                  cur_w_in = req_w0;
                  b0_in    = req_b0;
                  state_in = S_LOOK0;
               end
            end
         end
         S_LOOK0, S_LOOK1: begin
            if (take) begin
               word_vld_in[cur_w_ff] = 1'b1;
               if (taken_word == '1) full_in[cur_w_ff] = 1'b1;
               count_in              = count_take;
               rsp_valid_in          = 1'b1;
               rsp_in.slot_index     = SLOT_W'(int'(cur_w_ff) * WORD_BITS + int'(find_idx));
               rsp_in.failed         = 1'b0;
               rsp_in.slots_used     = CNT_W'(count_take);
               rsp_in.past_threshold = (COUNT_W + THR_W)'(count_take) >=
                                       (COUNT_W + THR_W)'(thr_ff);
               state_in              = S_IDLE;
            end else if (fail) begin
               rsp_valid_in          = 1'b1;
               rsp_in.slot_index     = '0;
               rsp_in.failed         = 1'b1;
               rsp_in.slots_used     = CNT_W'(count_ff);
               rsp_in.past_threshold = (COUNT_W + THR_W)'(count_ff) >=
                                       (COUNT_W + THR_W)'(thr_ff);
               state_in              = S_IDLE;
            end else begin
               cur_w_in = next_w;
               state_in = S_LOOK1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         word_vld_ff  <= '0;
         full_ff      <= '0;
         count_ff     <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_vld_ff  <= word_vld_in;
         full_ff      <= full_in;
         count_ff     <= count_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_w_ff <= cur_w_in;
      b0_ff    <= b0_in;
      rsp_ff   <= rsp_in;
   end

   // word store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) slot_mem[wr_addr] <= wr_data;
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= word_vld_in[rd_addr] && word_vld_ff[rd_addr];
      end
   end

   // a pending result means the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result pending while search is running");

   // a failed allocation only happens with every slot used
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.failed) |-> (count_ff == COUNT_W'(TOTAL_SLOTS)))
      else $error("allocation failed with free slots left");

   // used count never exceeds the store size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TOTAL_SLOTS))
      else $error("used count beyond store size");

   // a second search step only ever comes directly after the first
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK1) |-> ($past(state_ff) == S_LOOK0))
      else $error("second search step without first");

endmodule
